// File: rtl/core/eor_pkg.sv
// Shared constants, datapath commands and status types of the ellipse outline rasterizer.
package eor_pkg;

  localparam int DEF_RADIUS_BITS = 11;
  localparam int DEF_COORD_BITS  = 13;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SQ_RY,
    CMD_RXSQ_RY,
    CMD_INIT1,
    CMD_STEP1,
    CMD_STEP2,
    CMD_TX_SQ,
    CMD_RY_TX,
    CMD_TY_SQ,
    CMD_RX_TY,
    CMD_RXRY,
    CMD_INIT2
  } eor_cmd_t;

  typedef struct packed {
    logic rad_zero;
    logic region_exit;
    logic y_zero;
  } eor_stat_t;

endpackage

// File: rtl/core/eor_if.sv
// Request and point-group channel interfaces of the ellipse outline rasterizer.
interface eor_req_if #(
  parameter int COORD_BITS  = 13,
  parameter int RADIUS_BITS = 11
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius_x;
  logic        [RADIUS_BITS-1:0] radius_y;
  logic        [31:0]            color;

  modport source (output valid, req_type, center_x, center_y, radius_x, radius_y, color,
                  input ready);
  modport sink (input valid, req_type, center_x, center_y, radius_x, radius_y, color,
                output ready);
  modport mon (input valid, ready, req_type, center_x, center_y, radius_x, radius_y, color);
endinterface

interface eor_pix_if #(
  parameter int COORD_BITS = 13
);
  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS:0]  right_x;
  logic signed [COORD_BITS:0]  left_x;
  logic signed [COORD_BITS:0]  lower_y;
  logic signed [COORD_BITS:0]  upper_y;
  logic        [31:0]          pixel_color;
  logic                        last;

  modport source (output valid, right_x, left_x, lower_y, upper_y, pixel_color, last,
                  input ready);
  modport sink (input valid, right_x, left_x, lower_y, upper_y, pixel_color, last,
                output ready);
  modport mon (input valid, ready, right_x, left_x, lower_y, upper_y, pixel_color, last);
endinterface

// File: rtl/core/eor_ctrl.sv
// Controller state machine: sequences start, step and region switch commands.
module eor_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_req_type,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  eor_pkg::eor_stat_t stat,
  output eor_pkg::eor_cmd_t  cmd
);
  import eor_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_REG1, S_SETTLE, S_REG2,
    S_LD_RY, S_LD_RXRY, S_LD_INIT,
    S_SW_RYTX, S_SW_TY, S_SW_RXTY, S_SW_RXRY, S_SW_INIT
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept, produce;

  assign in_ready = (state == S_IDLE || state == S_REG1 || state == S_REG2) &&
                    (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign produce  = accept && (in_req_type == REQ_STEP) &&
                    (state == S_REG1 || state == S_REG2);

  always_comb begin
    cmd        = CMD_NONE;
    state_next = state;
    if (accept && in_req_type == REQ_START) begin
      cmd        = CMD_LOAD;
      state_next = S_LD_RY;
    end else begin
      case (state)
        S_IDLE:    state_next = S_IDLE;
        S_REG1: begin
          if (accept) begin
            cmd        = CMD_STEP1;
            state_next = S_SETTLE;
          end
        end
        S_REG2: begin
          if (accept) begin
            cmd        = CMD_STEP2;
            state_next = stat.y_zero ? S_IDLE : S_REG2;
          end
        end
        S_SETTLE: begin
          if (stat.region_exit) begin
            cmd        = CMD_TX_SQ;
            state_next = S_SW_RYTX;
          end else begin
            state_next = S_REG1;
          end
        end
        S_LD_RY: begin
          cmd        = CMD_SQ_RY;
          state_next = S_LD_RXRY;
        end
        S_LD_RXRY: begin
          cmd        = CMD_RXSQ_RY;
          state_next = S_LD_INIT;
        end
        S_LD_INIT: begin
          cmd        = CMD_INIT1;
          state_next = stat.rad_zero ? S_IDLE : S_REG1;
        end
        S_SW_RYTX: begin
          cmd        = CMD_RY_TX;
          state_next = S_SW_TY;
        end
        S_SW_TY: begin
          cmd        = CMD_TY_SQ;
          state_next = S_SW_RXTY;
        end
        S_SW_RXTY: begin
          cmd        = CMD_RX_TY;
          state_next = S_SW_RXRY;
        end
        S_SW_RXRY: begin
          cmd        = CMD_RXRY;
          state_next = S_SW_INIT;
        end
        S_SW_INIT: begin
          cmd        = CMD_INIT2;
          state_next = S_REG2;
        end
        default:   state_next = S_IDLE;
      endcase
    end
  end

  assign out_valid_next = (out_valid && !out_ready) || produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

// File: rtl/core/eor_dp.sv
// Datapath: ellipse registers, shared multiplier, decision update and point-group register.
module eor_dp #(
  parameter int RADIUS_BITS = 11,
  parameter int COORD_BITS  = 13
) (
  input  logic                          clk,
  input  eor_pkg::eor_cmd_t             cmd,
  output eor_pkg::eor_stat_t            stat,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic        [RADIUS_BITS-1:0] radius_x,
  input  logic        [RADIUS_BITS-1:0] radius_y,
  input  logic        [31:0]            color,
  output logic signed [COORD_BITS:0]    right_x,
  output logic signed [COORD_BITS:0]    left_x,
  output logic signed [COORD_BITS:0]    lower_y,
  output logic signed [COORD_BITS:0]    upper_y,
  output logic        [31:0]            pixel_color,
  output logic                          last
);
  import eor_pkg::*;

  localparam int R      = RADIUS_BITS;
  localparam int SQ_W   = 2 * R;
  localparam int OFF_W  = R + 2;
  localparam int DEC_W  = 4 * R + 4;
  localparam int MUL_W  = 2 * R + 4;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W;
  localparam int OUT_W  = COORD_BITS + 1;
  localparam int SUM_W  = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 1;

  logic signed [COORD_BITS-1:0] cx, cy;
  logic        [31:0]           draw_color;
  logic        [R-1:0]          rx_r, ry_r;
  logic        [SQ_W-1:0]       rxsq, rysq;
  logic signed [OFF_W-1:0]      x, y;
  logic signed [DEC_W-1:0]      dx, dy, dec;
  logic        [PROD_W-1:0]     mul_q;
  logic signed [ACC_W-1:0]      acc;

  logic        [MUL_W-1:0]      mul_a, mul_b, tx, aty;
  logic signed [DEC_W-1:0]      rxsq_e, rysq_e, dx_inc, dy_dec;
  logic signed [ACC_W-1:0]      q, mul_q4;
  logic signed [DEC_W-1:0]      q_div4;
  logic signed [OFF_W-1:0]      x_inc, y_dec;
  logic signed [SUM_W-1:0]      cx_e, cy_e, x_e, y_e;

  assign rxsq_e = DEC_W'(rxsq);
  assign rysq_e = DEC_W'(rysq);
  assign dx_inc = dx + (rysq_e <<< 1);
  assign dy_dec = dy - (rxsq_e <<< 1);
  assign x_inc  = x + OFF_W'(1);
  assign y_dec  = y - OFF_W'(1);

  // y never goes negative in region one, so |y-1| is 1 at y = 0 and y-1 otherwise.
  assign tx  = MUL_W'({x, 1'b1});
  assign aty = (y == '0) ? MUL_W'(1) : MUL_W'(y_dec);

  assign mul_q4 = ACC_W'({mul_q, 2'b00});

  always_comb begin
    case (cmd)
      CMD_LOAD:    begin mul_a = MUL_W'(radius_x); mul_b = MUL_W'(radius_x); end
      CMD_SQ_RY:   begin mul_a = MUL_W'(ry_r);     mul_b = MUL_W'(ry_r);     end
      CMD_RXSQ_RY: begin mul_a = MUL_W'(rxsq);     mul_b = MUL_W'(ry_r);     end
      CMD_TX_SQ:   begin mul_a = tx;               mul_b = tx;               end
      CMD_RY_TX:   begin mul_a = MUL_W'(rysq);     mul_b = mul_q[MUL_W-1:0]; end
      CMD_TY_SQ:   begin mul_a = aty;              mul_b = aty;              end
      CMD_RX_TY:   begin mul_a = MUL_W'(rxsq);     mul_b = mul_q[MUL_W-1:0]; end
      CMD_RXRY:    begin mul_a = MUL_W'(rxsq);     mul_b = MUL_W'(rysq);     end
      default:     begin mul_a = '0;               mul_b = '0;               end
    endcase
  end

  // Quarter-unit start value of either region, truncated toward zero on the divide by four.
  always_comb begin
    if (cmd == CMD_INIT1) begin
      q = ACC_W'({rysq, 2'b00}) - mul_q4 + ACC_W'(rxsq);
    end else begin
      q = acc - mul_q4;
    end
    q_div4 = DEC_W'((q < 0) ? ((q + ACC_W'(3)) >>> 2) : (q >>> 2));
  end

  assign stat.rad_zero    = (rx_r == '0) || (ry_r == '0);
  assign stat.region_exit = !(dx < dy);
  assign stat.y_zero      = (y == '0);

  assign cx_e = SUM_W'(cx);
  assign cy_e = SUM_W'(cy);
  assign x_e  = SUM_W'(x);
  assign y_e  = SUM_W'(y);

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    case (cmd)
      CMD_LOAD: begin
        cx         <= center_x;
        cy         <= center_y;
        draw_color <= color;
        rx_r       <= radius_x;
        ry_r       <= radius_y;
        x          <= '0;
        y          <= OFF_W'(radius_y);
      end
      CMD_SQ_RY:   rxsq <= mul_q[SQ_W-1:0];
      CMD_RXSQ_RY: rysq <= mul_q[SQ_W-1:0];
      CMD_INIT1: begin
        dec <= q_div4;
        dx  <= '0;
        dy  <= DEC_W'({mul_q, 1'b0});
      end
      CMD_STEP1: begin
        x  <= x_inc;
        dx <= dx_inc;
        if (dec < 0) begin
          dec <= dec + dx_inc + rysq_e;
        end else begin
          y   <= y_dec;
          dy  <= dy_dec;
          dec <= dec + dx_inc - dy_dec + rysq_e;
        end
      end
      CMD_STEP2: begin
        y  <= y_dec;
        dy <= dy_dec;
        if (dec > 0) begin
          dec <= dec + rxsq_e - dy_dec;
        end else begin
          x   <= x_inc;
          dx  <= dx_inc;
          dec <= dec + dx_inc - dy_dec + rxsq_e;
        end
      end
      CMD_TY_SQ:   acc <= ACC_W'(mul_q);
      CMD_RXRY:    acc <= acc + mul_q4;
      CMD_INIT2:   dec <= q_div4;
      default: ;
    endcase

    if (cmd == CMD_STEP1 || cmd == CMD_STEP2) begin
      right_x     <= OUT_W'(cx_e + x_e);
      left_x      <= OUT_W'(cx_e - x_e);
      lower_y     <= OUT_W'(cy_e + y_e);
      upper_y     <= OUT_W'(cy_e - y_e);
      pixel_color <= draw_color;
      last        <= (cmd == CMD_STEP2) && (y == '0);
    end
  end
endmodule

// File: rtl/core/ellipse_outline_rasterizer_top.sv
// Top level of the ellipse outline rasterizer: controller plus datapath.
//
//  channel  direction  protocol     payload
//  req      in         valid/ready  req_type, center_x, center_y, radius_x, radius_y, color
//  pix      out        valid/ready  right_x, left_x, lower_y, upper_y, pixel_color, last
//
// A start transfer occupies the block through the states S_LD_RY, S_LD_RXRY and S_LD_INIT,
// since the squares of both radii and the product rx^2*ry pass one after another through
// the single shared multiplier. A step in region one is the update, then the slope compare;
// on the step that leaves region one, the region two start value is then built from five
// chained multiplies. A step in region two has no slope compare.
// Reset returns the controller to idle and empties the output register.
// A held result stalls only the next request; the register is freed when pix is taken.
module ellipse_outline_rasterizer_top #(
  parameter int RADIUS_BITS = eor_pkg::DEF_RADIUS_BITS,
  parameter int COORD_BITS  = eor_pkg::DEF_COORD_BITS
) (
  input logic       clk,
  input logic       rst,
  eor_req_if.sink   req,
  eor_pix_if.source pix
);
  import eor_pkg::*;

  eor_cmd_t  cmd;
  eor_stat_t stat;

  // The controller owns the handshakes and the sequencing; everything wide is in the datapath.
  eor_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (req.ready),
    .out_valid   (pix.valid),
    .out_ready   (pix.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // The datapath keeps the ellipse, the incremental slope terms and the result register.
  eor_dp #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .center_x    (req.center_x),
    .center_y    (req.center_y),
    .radius_x    (req.radius_x),
    .radius_y    (req.radius_y),
    .color       (req.color),
    .right_x     (pix.right_x),
    .left_x      (pix.left_x),
    .lower_y     (pix.lower_y),
    .upper_y     (pix.upper_y),
    .pixel_color (pix.pixel_color),
    .last        (pix.last)
  );
endmodule

// File: rtl/core/eor_checker.sv
// Port-level assertions of the ellipse outline rasterizer and their bind.
module eor_checker (
  input logic       clk,
  input logic       rst,
  eor_req_if.sink   req,
  eor_pix_if.source pix
);
  import eor_pkg::*;

  // A start spends the following cycles on the radius products, so no request is taken.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.req_type == REQ_START) |=> !req.ready)
    else $error("request taken right after a start transfer");

  // A start never produces a point group.
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.req_type == REQ_START && !pix.valid) |=> !pix.valid)
    else $error("point group appeared after a start transfer");

  // Every new point group is caused by a step transfer in the cycle before.
  a_step_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(pix.valid) |-> $past(req.valid && req.ready && req.req_type == REQ_STEP))
    else $error("point group without a step transfer");

  // A stalled point group holds.
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && !pix.ready) |=>
      (pix.valid && $stable(pix.right_x) && $stable(pix.upper_y) && $stable(pix.last)))
    else $error("stalled point group changed");
endmodule

bind ellipse_outline_rasterizer_top eor_checker u_eor_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .pix (pix)
);

// File: dv/ellipse_outline_rasterizer_top_tb.sv
// Self-checking testbench for the ellipse outline rasterizer: directed and random ellipse walks.
module ellipse_outline_rasterizer_top_tb;
  import eor_pkg::*;

  localparam int RB = DEF_RADIUS_BITS;
  localparam int CB = DEF_COORD_BITS;
  localparam int OW = CB + 1;

  // Run shape. The watchdog limit covers the long receiver hold-off plus the slowest
  // region-switch step under random stalls, several times over. The random part comes
  // on top of the 25 directed requests.
  localparam int RANDOM_ITEMS   = 1425;
  localparam int IDLE_PERCENT   = 35;
  localparam int HOLD_AT        = 1000;
  localparam int HOLD_CYCLES    = 400;
  localparam int STEADY_FROM    = 2500;
  localparam int STEADY_TO      = 4000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;

  typedef struct {
    logic                 req_type;
    logic signed [CB-1:0] center_x, center_y;
    logic        [RB-1:0] radius_x, radius_y;
    logic        [31:0]   color;
  } ellipse_req_t;

  typedef struct {
    logic signed [CB:0] right_x, left_x, lower_y, upper_y;
    logic        [31:0] pixel_color;
    logic               last;
  } point_group_t;

  // Walk position of the predicted ellipse: not drawing, above the slope-one point,
  // or below it.
  typedef enum logic [1:0] {WALK_IDLE, WALK_REGION1, WALK_REGION2} walk_phase_t;

  logic clk = 1'b0;
  logic rst;

  eor_req_if #(.COORD_BITS(CB), .RADIUS_BITS(RB)) req_ch ();
  eor_pix_if #(.COORD_BITS(CB)) pix_ch ();

  ellipse_outline_rasterizer_top #(.RADIUS_BITS(RB), .COORD_BITS(CB)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .pix(pix_ch)
  );

  always #5 clk = ~clk;

  // Predicted ellipse state. All arithmetic is 64-bit, which is wide enough for every
  // product of squared radii and offsets, so nothing here can overflow.
  walk_phase_t  walk_phase;
  longint       ctr_col, ctr_row;
  longint       rx_sq, ry_sq;
  longint       off_x, off_y;
  longint       decision;
  logic [31:0]  walk_color;

  ellipse_req_t stim_queue[$];
  point_group_t expected_groups[$];

  int  cycle_count;
  int  quiet_cycles;
  int  hold_left;
  int  mismatch_count = 0;
  logic steady_stretch;

  // Neither side idles in this window, so the block runs at its own full rate for a while.
  assign steady_stretch = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

  // Predicted state after reset.
  function automatic void reset_prediction();
    walk_phase = WALK_IDLE;
    ctr_col    = 0;
    ctr_row    = 0;
    rx_sq      = 0;
    ry_sq      = 0;
    off_x      = 0;
    off_y      = 0;
    decision   = 0;
    walk_color = '0;
  endfunction

  // Once the slope reaches minus one, the walk moves to region two and the decision
  // variable is rebuilt from the current offsets, in quarter units truncated toward zero.
  function automatic void enter_region_two_if_due();
    longint tx, ty;
    if (walk_phase == WALK_REGION1 && !(ry_sq * off_x < rx_sq * off_y)) begin
      tx = 2 * off_x + 1;
      ty = off_y - 1;
      decision = (ry_sq * tx * tx + 4 * rx_sq * ty * ty - 4 * rx_sq * ry_sq) / 4;
      walk_phase = WALK_REGION2;
    end
  endfunction

  // Applies one accepted request to the predicted ellipse and queues the point group
  // that a step should produce.
  function automatic void advance_ellipse(ellipse_req_t r);
    longint       rx, ry;
    point_group_t g;
    if (r.req_type == REQ_START) begin
      // A start always restarts the walk, even in the middle of another ellipse.
      rx         = longint'(r.radius_x);
      ry         = longint'(r.radius_y);
      ctr_col    = longint'(r.center_x);
      ctr_row    = longint'(r.center_y);
      walk_color = r.color;
      rx_sq      = rx * rx;
      ry_sq      = ry * ry;
      off_x      = 0;
      off_y      = ry;
      if (rx == 0 || ry == 0) begin
        decision   = 0;
        walk_phase = WALK_IDLE;
      end else begin
        decision   = (4 * ry_sq - 4 * rx_sq * ry + rx_sq) / 4;
        walk_phase = WALK_REGION1;
        enter_region_two_if_due();
      end
    end else if (walk_phase != WALK_IDLE) begin
      // The group reports the offsets as they stand before this step moves them.
      // Assignment to the 14-bit fields wraps the sums to the output width.
      g.right_x     = OW'(ctr_col + off_x);
      g.left_x      = OW'(ctr_col - off_x);
      g.lower_y     = OW'(ctr_row + off_y);
      g.upper_y     = OW'(ctr_row - off_y);
      g.pixel_color = walk_color;
      g.last        = 1'b0;
      if (walk_phase == WALK_REGION1) begin
        off_x = off_x + 1;
        if (decision < 0) begin
          decision = decision + 2 * ry_sq * off_x + ry_sq;
        end else begin
          off_y    = off_y - 1;
          decision = decision + 2 * ry_sq * off_x - 2 * rx_sq * off_y + ry_sq;
        end
        enter_region_two_if_due();
      end else begin
        off_y = off_y - 1;
        if (decision > 0) begin
          decision = decision + rx_sq - 2 * rx_sq * off_y;
        end else begin
          off_x    = off_x + 1;
          decision = decision + 2 * ry_sq * off_x - 2 * rx_sq * off_y + rx_sq;
        end
        // The group drawn at y = 0 closes the outline.
        if (off_y < 0) begin
          g.last     = 1'b1;
          walk_phase = WALK_IDLE;
        end
      end
      expected_groups = {expected_groups, g};
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic queue_start(int cx, int cy, int rx, int ry, logic [31:0] col);
    ellipse_req_t r;
    r.req_type = REQ_START;
    r.center_x = CB'(cx);
    r.center_y = CB'(cy);
    r.radius_x = RB'(rx);
    r.radius_y = RB'(ry);
    r.color    = col;
    stim_queue = {stim_queue, r};
  endtask

  // Step requests carry random junk in the fields that the block ignores on a step.
  task automatic queue_steps(int n);
    ellipse_req_t r;
    repeat (n) begin
      r.req_type = REQ_STEP;
      r.center_x = CB'($urandom);
      r.center_y = CB'($urandom);
      r.radius_x = RB'($urandom);
      r.radius_y = RB'($urandom);
      r.color    = $urandom;
      stim_queue = {stim_queue, r};
    end
  endtask

  // Request driver. A new request is presented only when the current one has been
  // transferred, so valid never drops while an item is waiting.
  always @(posedge clk) begin
    ellipse_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (stim_queue.size() != 0 &&
          (steady_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        nxt = stim_queue.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= nxt.req_type;
        req_ch.center_x <= nxt.center_x;
        req_ch.center_y <= nxt.center_y;
        req_ch.radius_x <= nxt.radius_x;
        req_ch.radius_y <= nxt.radius_y;
        req_ch.color    <= nxt.color;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Point-group receiver. Once in the run it refuses everything for a long stretch while
  // the driver keeps offering requests, which fills the output register and backs the
  // stall up into the request channel.
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      pix_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (cycle_count == HOLD_AT) begin
      pix_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
    end else begin
      pix_ch.ready <= steady_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Monitor and watchdog. A result is checked before the request of the same edge is
  // predicted, since that request cannot have produced it.
  always @(posedge clk) begin
    point_group_t want;
    ellipse_req_t seen;
    if (rst) begin
      cycle_count  <= 0;
      quiet_cycles <= 0;
      reset_prediction();
    end else begin
      cycle_count <= cycle_count + 1;
      if (pix_ch.valid && pix_ch.ready) begin
        if (expected_groups.size() == 0) begin
          $error("unexpected point group: right_x %0d, upper_y %0d, last %0b",
                 pix_ch.right_x, pix_ch.upper_y, pix_ch.last);
          mismatch_count++;
        end else begin
          want = expected_groups.pop_front();
          check_field("right_x", 32'(want.right_x), 32'(pix_ch.right_x));
          check_field("left_x", 32'(want.left_x), 32'(pix_ch.left_x));
          check_field("lower_y", 32'(want.lower_y), 32'(pix_ch.lower_y));
          check_field("upper_y", 32'(want.upper_y), 32'(pix_ch.upper_y));
          check_field("pixel_color", want.pixel_color, pix_ch.pixel_color);
          check_field("last", 32'(want.last), 32'(pix_ch.last));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.req_type = req_ch.req_type;
        seen.center_x = req_ch.center_x;
        seen.center_y = req_ch.center_y;
        seen.radius_x = req_ch.radius_x;
        seen.radius_y = req_ch.radius_y;
        seen.color    = req_ch.color;
        advance_ellipse(seen);
      end
      if ((pix_ch.valid && pix_ch.ready) || (req_ch.valid && req_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int counted, pick, rx, ry, span, steps;

    rst = 1'b1;

    // Directed part. A step straight out of reset has no ellipse to walk.
    queue_steps(1);
    // A zero radius on either axis leaves the block idle, so the following step is dropped.
    queue_start(10, 20, 0, 5, 32'h1234_5678);
    queue_steps(1);
    queue_start(-30, 40, 5, 0, 32'h8765_4321);
    queue_steps(1);
    // Smallest ellipse at the most negative corner. It closes after two groups; the third
    // step finds the block idle again.
    queue_start(-4096, -4096, 1, 1, 32'h0000_0000);
    queue_steps(3);
    // Largest radii at the most positive corner; the walk is cut short by the next start.
    queue_start(4095, 4095, 2047, 2047, 32'hFFFF_FFFF);
    queue_steps(3);
    // A tall, narrow ellipse, walked to the end, so both regions and both branches of
    // the decision rule are exercised.
    queue_start(100, -50, 3, 7, 32'hA5A5_5A5A);
    queue_steps(11);

    // Random part. Most items are well-formed walks with random content, mainly small
    // radii so that many outlines finish. Some walks are cut short or overrun, and some
    // items are stray steps or lone starts. Every queued request is counted.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if ($urandom_range(0, 1) == 1) begin
          steps = $urandom_range(1, 3);
          queue_steps(steps);
          counted += steps;
        end else begin
          queue_start($urandom, $urandom, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom);
          counted++;
        end
      end else begin
        if (pick < 80) begin
          rx = $urandom_range(1, 12);
          ry = $urandom_range(1, 12);
        end else if (pick < 92) begin
          rx = $urandom_range(1, 60);
          ry = $urandom_range(1, 60);
        end else if (pick < 96) begin
          rx = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 2047);
          ry = (rx == 0) ? $urandom_range(0, 2047) : 0;
        end else begin
          rx = $urandom_range(0, 2047);
          ry = $urandom_range(0, 2047);
        end
        // An outline never has more than rx + ry + 1 groups.
        span = rx + ry + 2;
        if (rx + ry > 130) begin
          steps = $urandom_range(0, 30);
        end else if ($urandom_range(0, 3) == 0) begin
          steps = $urandom_range(0, span);
        end else begin
          steps = span + $urandom_range(0, 2);
        end
        queue_start($urandom, $urandom, rx, ry, $urandom);
        queue_steps(steps);
        counted += 1 + steps;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be transferred, then for every predicted group, then
    // give the block time to show any group that nobody expects.
    while (stim_queue.size() != 0 || req_ch.valid) @(negedge clk);
    while (expected_groups.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
